/* sv/sme_pkg.sv */
// ----------------------------------------------------------------------------
// sme_pkg
// Shared types and codes of the stack machine executor.
// ----------------------------------------------------------------------------
package sme_pkg;

  localparam int unsigned VW = 48;

  typedef logic [3:0] cmd_t;
  localparam cmd_t CMD_PUSH = 4'd0;
  localparam cmd_t CMD_POP  = 4'd1;
  localparam cmd_t CMD_IN   = 4'd2;
  localparam cmd_t CMD_MUL  = 4'd3;
  localparam cmd_t CMD_SUB  = 4'd4;
  localparam cmd_t CMD_OUT  = 4'd5;
  localparam cmd_t CMD_ADD  = 4'd6;
  localparam cmd_t CMD_DIV  = 4'd7;
  localparam cmd_t CMD_SQRT = 4'd8;

  typedef logic [2:0] err_t;
  localparam err_t ERR_NONE  = 3'd0;
  localparam err_t ERR_DIV0  = 3'd1;
  localparam err_t ERR_UNDER = 3'd2;
  localparam err_t ERR_OVER  = 3'd3;
  localparam err_t ERR_SQRT  = 3'd4;

  localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  // decoded instruction handed from front to back
  typedef struct packed {
    cmd_t             cmd;
    logic [2:0]       reg_sel;
    logic [VW-1:0]    operand;
  } instr_t;

  // result item
  typedef struct packed {
    logic [VW-1:0] out_value;
    logic          out_valid;
    logic          halted;
    err_t          error_code;
  } result_t;

endpackage

/* sv/sme_if.sv */
// ----------------------------------------------------------------------------
// sme_if
// Valid/ready channels of the stack machine executor.
// ----------------------------------------------------------------------------
interface sme_in_if;
  logic             valid;
  logic             ready;
  logic [3:0]       cmd;
  logic [2:0]       reg_sel;
  logic [47:0]      immediate;
  logic [47:0]      in_value;
  modport source (output valid, cmd, reg_sel, immediate, in_value, input ready);
  modport sink (input valid, cmd, reg_sel, immediate, in_value, output ready);
endinterface

interface sme_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] out_value;
  logic        out_valid;
  logic        halted;
  logic [2:0]  error_code;
  modport source (output valid, out_value, out_valid, halted, error_code, input ready);
  modport sink (input valid, out_value, out_valid, halted, error_code, output ready);
endinterface

/* sv/sme_front.sv */
// ----------------------------------------------------------------------------
// sme_front
// Accepts instructions, selects the operand and queues them for the back end.
// ----------------------------------------------------------------------------
module sme_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [3:0]          cmd_i,
  input  logic [2:0]          reg_sel_i,
  input  logic [47:0]         immediate_i,
  input  logic [47:0]         in_value_i,
  output logic                q_valid_o,
  input  logic                q_pop_i,
  output sme_pkg::instr_t     q_data_o
);

  sme_pkg::instr_t     mem_q [2];
  logic                wp_q, rp_q, wp_d, rp_d;
  logic [1:0]          cnt_q, cnt_d;
  logic                push;
  sme_pkg::instr_t     ins;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = mem_q[rp_q];

  // classify: in carries in_value, everything else the immediate
  always_comb begin
    ins.cmd     = cmd_i;
    ins.reg_sel = reg_sel_i;
    ins.operand = (cmd_i == sme_pkg::CMD_IN) ? in_value_i : immediate_i;
  end

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = q_pop_i ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      wp_q <= wp_d; rp_q <= rp_d; cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= ins;
  end

endmodule

/* sv/sme_divsqrt.sv */
// ----------------------------------------------------------------------------
// sme_divsqrt
// Iterative unsigned divide (72 steps) and square root (36 steps).
// ----------------------------------------------------------------------------
module sme_divsqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        is_sqrt_i,
  input  logic [47:0] a_i,
  input  logic [47:0] d_i,
  output logic        done_o,
  output logic [48:0] res_o
);

  logic        busy_q, busy_d, sq_q, sq_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [71:0] num_q, num_d;
  logic [73:0] rem_q, rem_d;
  logic [71:0] q_q, q_d;
  logic [47:0] den_q, den_d;
  logic [73:0] trial;
  logic [73:0] r2;

  assign done_o = busy_q && (cnt_q == 7'd0);
  // saturation when quotient exceeds 48 bits
  assign res_o = sq_q ? {13'd0, q_q[35:0]} :
                 ((q_q[71:48] != '0) ? {1'b1, 48'd0} : {1'b0, q_q[47:0]});

  always_comb begin
    busy_d = busy_q; sq_d = sq_q; cnt_d = cnt_q;
    num_d = num_q; rem_d = rem_q; q_d = q_q; den_d = den_q;
    r2 = '0; trial = '0;
    if (start_i) begin
      busy_d = 1'b1; sq_d = is_sqrt_i;
      num_d  = {a_i, 24'd0};
      rem_d  = '0; q_d = '0; den_d = d_i;
      cnt_d  = is_sqrt_i ? 7'd36 : 7'd72;
    end else if (busy_q && cnt_q != 7'd0) begin
      cnt_d = cnt_q - 7'd1;
      if (sq_q) begin
        // restoring square root, two bits per step
        r2    = {rem_q[71:0], num_q[71:70]};
        trial = {q_q[71:0], 2'b01};
        num_d = {num_q[69:0], 2'b00};
        if (r2 >= trial) begin
          rem_d = r2 - trial; q_d = {q_q[70:0], 1'b1};
        end else begin
          rem_d = r2; q_d = {q_q[70:0], 1'b0};
        end
      end else begin
        r2    = {rem_q[72:0], num_q[71]};
        num_d = {num_q[70:0], 1'b0};
        if (r2 >= {26'd0, den_q}) begin
          rem_d = r2 - {26'd0, den_q}; q_d = {q_q[70:0], 1'b1};
        end else begin
          rem_d = r2; q_d = {q_q[70:0], 1'b0};
        end
      end
    end else if (done_o) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= 7'd0; sq_q <= 1'b0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d; sq_q <= sq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; q_q <= q_d; den_q <= den_d;
  end

endmodule

/* sv/sme_back.sv */
// ----------------------------------------------------------------------------
// sme_back
// Executes queued instructions against the stack and registers.
// ----------------------------------------------------------------------------
module sme_back #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [46:0]         zero_threshold_i,
  input  logic                q_valid_i,
  output logic                q_pop_o,
  input  sme_pkg::instr_t     q_data_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output sme_pkg::result_t    res_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD1  = 4'd1;
  localparam logic [3:0] S_RD2  = 4'd2;
  localparam logic [3:0] S_EXEC = 4'd3;
  localparam logic [3:0] S_MUL1 = 4'd4;
  localparam logic [3:0] S_MUL2 = 4'd5;
  localparam logic [3:0] S_MUL3 = 4'd6;
  localparam logic [3:0] S_ITER = 4'd7;
  localparam logic [3:0] S_WB   = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]       st_q, st_d;
  logic [47:0]      stk [STACK_DEPTH];
  logic [47:0]      rd_q;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [47:0]      wr_data;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [47:0]      regs_q [4];
  logic             halt_q, halt_d;
  sme_pkg::err_t    err_q, err_d;
  sme_pkg::instr_t  ins_q, ins_d;
  logic [47:0]      top_q, top_d, nxt_q, nxt_d;
  logic [47:0]      res_val_q, res_val_d;
  logic             neg_q, neg_d;
  logic [47:0]      ma_q, mb_q, ma_d, mb_d;
  logic [47:0]      pp_q [4];
  logic [95:0]      prod_q, prod_d;
  logic [48:0]      mag_res;
  logic [47:0]      sat_res;
  sme_pkg::result_t out_q, out_d;
  logic             ov_q, ov_d;
  logic             reg_we;
  logic             ds_start, ds_sqrt, ds_done;
  logic [48:0]      ds_res;
  logic [48:0]      sum;
  logic [47:0]      nmag;

  function automatic logic [47:0] mag48(input logic [47:0] v);
    mag48 = v[47] ? (48'd0 - v) : v;
  endfunction

  function automatic logic [47:0] sat49(input logic [48:0] s);
    if (s[48] != s[47]) sat49 = s[48] ? sme_pkg::VMIN : sme_pkg::VMAX;
    else sat49 = s[47:0];
  endfunction

  // operands are taken at the start edge, so they come from the next-state values
  sme_divsqrt u_ds (
    .clk_i, .rst_ni, .start_i(ds_start), .is_sqrt_i(ds_sqrt), .a_i(ma_d), .d_i(mb_d),
    .done_o(ds_done), .res_o(ds_res)
  );

  assign res_valid_o = ov_q;
  assign res_o       = out_q;
  assign q_pop_o     = (st_q == S_IDLE) && q_valid_i && !ov_q;
  assign nmag        = mag48(nxt_q);

  // sign and magnitude back to a saturated value
  always_comb begin
    mag_res = (st_q == S_MUL3) ? ((prod_q[95:72] != '0) ? {1'b1, 48'd0}
                                                         : {1'b0, prod_q[71:24]}) : ds_res;
    if (neg_q) sat_res = (mag_res >= 49'h0_8000_0000_0000) ? sme_pkg::VMIN
                                                           : (48'd0 - mag_res[47:0]);
    else sat_res = (mag_res > 49'h0_7FFF_FFFF_FFFF) ? sme_pkg::VMAX : mag_res[47:0];
  end

  // multiplier partial products, 24x24 halves
  always_ff @(posedge clk_i) begin
    pp_q[0] <= 48'(ma_q[23:0] * mb_q[23:0]);
    pp_q[1] <= 48'(ma_q[23:0] * mb_q[47:24]);
    pp_q[2] <= 48'(ma_q[47:24] * mb_q[23:0]);
    pp_q[3] <= 48'(ma_q[47:24] * mb_q[47:24]);
  end

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; halt_d = halt_q; err_d = err_q; ins_d = ins_q;
    top_d = top_q; nxt_d = nxt_q; res_val_d = res_val_q; neg_d = neg_q;
    ma_d = ma_q; mb_d = mb_q; prod_d = prod_q; out_d = out_q; ov_d = ov_q;
    rd_addr = '0; wr_en = 1'b0; wr_addr = '0; wr_data = '0; reg_we = 1'b0;
    ds_start = 1'b0; ds_sqrt = 1'b0; sum = '0;
    if (ov_q && res_ready_i) ov_d = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (q_pop_o) begin
          ins_d = q_data_i;
          if (halt_q) begin
            st_d = S_OUT; res_val_d = '0;
          end else begin
            rd_addr = AW'(cnt_q - CW'(1));
            st_d = S_RD1;
          end
        end
      end
      S_RD1: begin
        top_d   = rd_q;
        rd_addr = AW'(cnt_q - CW'(2));
        st_d    = S_RD2;
      end
      S_RD2: begin
        nxt_d = rd_q;
        st_d  = S_EXEC;
      end
      S_EXEC: begin
        st_d = S_OUT; res_val_d = '0;
        ma_d = mag48(top_q); mb_d = nmag;
        neg_d = top_q[47] ^ nxt_q[47];
        case (ins_q.cmd)
          sme_pkg::CMD_PUSH, sme_pkg::CMD_IN: begin
            if (cnt_q >= FULL) begin
              halt_d = 1'b1; err_d = sme_pkg::ERR_OVER;
            end else begin
              wr_en = 1'b1; wr_addr = AW'(cnt_q);
              if (ins_q.cmd == sme_pkg::CMD_PUSH && ins_q.reg_sel < 3'd4)
                wr_data = regs_q[ins_q.reg_sel[1:0]];
              else wr_data = ins_q.operand;
              cnt_d = cnt_q + CW'(1);
            end
          end
          sme_pkg::CMD_POP, sme_pkg::CMD_OUT: begin
            if (cnt_q == '0) begin
              halt_d = 1'b1; err_d = sme_pkg::ERR_UNDER;
            end else begin
              cnt_d = cnt_q - CW'(1);
              if (ins_q.cmd == sme_pkg::CMD_OUT) res_val_d = top_q;
              else reg_we = (ins_q.reg_sel < 3'd4);
            end
          end
          sme_pkg::CMD_ADD, sme_pkg::CMD_SUB, sme_pkg::CMD_MUL, sme_pkg::CMD_DIV: begin
            if (cnt_q < CW'(2)) begin
              halt_d = 1'b1; err_d = sme_pkg::ERR_UNDER;
            end else begin
              cnt_d = cnt_q - CW'(1);
              wr_addr = AW'(cnt_q - CW'(2));
              if (ins_q.cmd == sme_pkg::CMD_ADD || ins_q.cmd == sme_pkg::CMD_SUB) begin
                sum = (ins_q.cmd == sme_pkg::CMD_ADD)
                    ? ({top_q[47], top_q} + {nxt_q[47], nxt_q})
                    : ({top_q[47], top_q} - {nxt_q[47], nxt_q});
                wr_en = 1'b1; wr_data = sat49(sum);
              end else if (ins_q.cmd == sme_pkg::CMD_MUL) begin
                st_d = S_MUL1;
              end else if (nmag == '0 || {1'b0, nmag} < {2'b0, zero_threshold_i}) begin
                cnt_d = cnt_q - CW'(2);
                halt_d = 1'b1; err_d = sme_pkg::ERR_DIV0;
              end else begin
                st_d = S_ITER; ds_start = 1'b1;
              end
            end
          end
          sme_pkg::CMD_SQRT: begin
            if (cnt_q == '0) begin
              halt_d = 1'b1; err_d = sme_pkg::ERR_UNDER;
            end else if (top_q[47]) begin
              cnt_d = cnt_q - CW'(1);
              halt_d = 1'b1; err_d = sme_pkg::ERR_SQRT;
            end else begin
              neg_d = 1'b0; ma_d = top_q;
              st_d = S_ITER; ds_start = 1'b1; ds_sqrt = 1'b1;
            end
          end
          default: begin
            halt_d = 1'b1; err_d = sme_pkg::ERR_NONE;
          end
        endcase
      end
      S_MUL1: st_d = S_MUL2;
      S_MUL2: begin
        prod_d = {pp_q[3], pp_q[0]} + {24'd0, pp_q[1], 24'd0} + {24'd0, pp_q[2], 24'd0};
        st_d = S_MUL3;
      end
      S_MUL3, S_WB: begin
        wr_en = 1'b1; wr_data = sat_res;
        wr_addr = AW'(cnt_q - CW'(1));
        st_d = S_OUT;
      end
      S_ITER: begin
        if (ds_done) st_d = S_WB;
      end
      S_OUT: begin
        if (!ov_q || res_ready_i) begin
          ov_d = 1'b1;
          out_d.out_value  = res_val_q;
          out_d.out_valid  = !halt_q && (ins_q.cmd == sme_pkg::CMD_OUT);
          out_d.halted     = halt_q;
          out_d.error_code = err_q;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; cnt_q <= '0; halt_q <= 1'b0; err_q <= sme_pkg::ERR_NONE;
      ov_q <= 1'b0;
      for (int i = 0; i < 4; i++) regs_q[i] <= '0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; halt_q <= halt_d; err_q <= err_d; ov_q <= ov_d;
      if (reg_we) regs_q[ins_q.reg_sel[1:0]] <= top_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ins_q <= ins_d; top_q <= top_d; nxt_q <= nxt_d; res_val_q <= res_val_d;
    neg_q <= neg_d; ma_q <= ma_d; mb_q <= mb_d; prod_q <= prod_d; out_q <= out_d;
  end

  // operand stack memory
  always_ff @(posedge clk_i) begin
    if (wr_en) stk[wr_addr] <= wr_data;
    rd_q <= stk[rd_addr];
  end

endmodule

/* sv/stack_machine_executor.sv */
// ----------------------------------------------------------------------------
// stack_machine_executor
// Stack machine with Q24.24 arithmetic, queued front end and execution back end.
// ----------------------------------------------------------------------------
// Each instruction returns one result. Mul forms four 24x24 partial products;
// div and sqrt use the iterative divide/square-root unit that produces one
// quotient bit (or one root bit) per cycle. A two-entry queue lets the front
// accept instructions while the back executes.
module stack_machine_executor #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  sme_in_if.sink      in_if,
  sme_out_if.source   out_if
);

  logic [46:0]      thr_q;
  logic             q_valid, q_pop;
  sme_pkg::instr_t  q_data;
  sme_pkg::result_t res;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[3] == 1'b0) ? {17'd0, thr_q} : 64'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) thr_q <= 47'd1;
    else if (psel && penable && pwrite && paddr[3] == 1'b0) thr_q <= pwdata[46:0];
  end

  sme_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .cmd_i(in_if.cmd), .reg_sel_i(in_if.reg_sel),
    .immediate_i(in_if.immediate), .in_value_i(in_if.in_value),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  sme_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk_i, .rst_ni, .zero_threshold_i(thr_q),
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .res_valid_o(out_if.valid), .res_ready_i(out_if.ready), .res_o(res)
  );

  assign out_if.out_value  = res.out_value;
  assign out_if.out_valid  = res.out_valid;
  assign out_if.halted     = res.halted;
  assign out_if.error_code = res.error_code;

endmodule

/* sim/sme_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sme_checker
// Watches the instruction and result channels and the register port of the
// stack machine executor, predicts every result from its own copy of the
// machine state, and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module sme_checker #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  sme_in_if           in_if,
  sme_out_if          out_if,
  output int          fail_count,
  output int          outstanding
);

  localparam logic [3:0] ADDR_THRESHOLD = 4'd0;

  // shadow machine state
  logic signed [47:0] stk [DEPTH];
  int                 depth_used;
  logic signed [47:0] gpr [4];
  bit                 stopped;
  sme_pkg::err_t      err_latch;
  logic [46:0]        thr;
  sme_pkg::result_t   expected_q [$];
  int                 nfail;

  function automatic logic [47:0] magn(logic signed [47:0] v);
    return v[47] ? 48'(-v) : 48'(v);
  endfunction

  // sign and magnitude back to a value, clamped to the 48-bit range
  function automatic logic [47:0] clip_to_q(bit neg, logic [127:0] m);
    if (neg) begin
      if (m >= 128'h8000_0000_0000) return sme_pkg::VMIN;
      return 48'(-m[47:0]);
    end
    if (m > 128'h7FFF_FFFF_FFFF) return sme_pkg::VMAX;
    return m[47:0];
  endfunction

  function automatic logic [47:0] q_sqrt(logic [47:0] v);
    logic [127:0] x;
    logic [127:0] root;
    logic [127:0] c;
    x = {80'b0, v} << 24;
    root = '0;
    for (int b = 35; b >= 0; b--) begin
      c = root | (128'(1) << b);
      if (c * c <= x) root = c;
    end
    return root[47:0];
  endfunction

  function automatic void stop_machine(sme_pkg::err_t e);
    stopped = 1'b1;
    err_latch = e;
  endfunction

  // one instruction against the shadow state
  function automatic sme_pkg::result_t execute(sme_pkg::cmd_t c, logic [2:0] rs,
                                               logic [47:0] imm, logic [47:0] inv);
    sme_pkg::result_t   r;
    logic signed [47:0] a;
    logic signed [47:0] b;
    logic signed [47:0] v;
    logic signed [48:0] s;
    logic [47:0]        ma;
    logic [47:0]        mb;
    r = '0;
    if (!stopped) begin
      case (c)
        sme_pkg::CMD_PUSH, sme_pkg::CMD_IN: begin
          if (depth_used >= DEPTH) begin
            stop_machine(sme_pkg::ERR_OVER);
          end else begin
            if (c == sme_pkg::CMD_IN) v = inv;
            else if (rs < 3'd4) v = gpr[rs[1:0]];
            else v = imm;
            stk[depth_used] = v;
            depth_used++;
          end
        end
        sme_pkg::CMD_POP, sme_pkg::CMD_OUT: begin
          if (depth_used == 0) begin
            stop_machine(sme_pkg::ERR_UNDER);
          end else begin
            depth_used--;
            v = stk[depth_used];
            if (c == sme_pkg::CMD_OUT) begin
              r.out_value = v;
              r.out_valid = 1'b1;
            end else if (rs < 3'd4) begin
              gpr[rs[1:0]] = v;
            end
          end
        end
        sme_pkg::CMD_MUL, sme_pkg::CMD_SUB, sme_pkg::CMD_ADD, sme_pkg::CMD_DIV: begin
          if (depth_used < 2) begin
            stop_machine(sme_pkg::ERR_UNDER);
          end else begin
            a = stk[depth_used-1];
            b = stk[depth_used-2];
            depth_used -= 2;
            ma = magn(a);
            mb = magn(b);
            if (c == sme_pkg::CMD_DIV && (mb == 0 || mb < {1'b0, thr})) begin
              stop_machine(sme_pkg::ERR_DIV0);
            end else begin
              case (c)
                sme_pkg::CMD_MUL:
                  v = clip_to_q(a[47] ^ b[47], (128'(ma) * 128'(mb)) >> 24);
                sme_pkg::CMD_DIV:
                  v = clip_to_q(a[47] ^ b[47], (128'(ma) << 24) / 128'(mb));
                default: begin
                  if (c == sme_pkg::CMD_ADD) s = 49'(a) + 49'(b);
                  else s = 49'(a) - 49'(b);
                  if (s[48] != s[47]) v = s[48] ? sme_pkg::VMIN : sme_pkg::VMAX;
                  else v = s[47:0];
                end
              endcase
              stk[depth_used] = v;
              depth_used++;
            end
          end
        end
        sme_pkg::CMD_SQRT: begin
          if (depth_used == 0) begin
            stop_machine(sme_pkg::ERR_UNDER);
          end else if (stk[depth_used-1][47]) begin
            depth_used--;
            stop_machine(sme_pkg::ERR_SQRT);
          end else begin
            stk[depth_used-1] = q_sqrt(stk[depth_used-1]);
          end
        end
        default: stop_machine(sme_pkg::ERR_NONE);
      endcase
    end
    r.halted = stopped;
    r.error_code = err_latch;
    return r;
  endfunction

  // predict on instruction transfers, compare on result transfers
  always @(posedge clk_i or negedge rst_ni) begin
    sme_pkg::result_t e;
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) stk[i] = '0;
      for (int i = 0; i < 4; i++) gpr[i] = '0;
      depth_used = 0;
      stopped = 1'b0;
      err_latch = sme_pkg::ERR_NONE;
      thr = 47'd1;
      expected_q.delete();
      nfail = 0;
      fail_count <= 0;
      outstanding <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_THRESHOLD)
        thr = pwdata[46:0];
      if (in_if.valid && in_if.ready)
        expected_q.push_back(execute(in_if.cmd, in_if.reg_sel, in_if.immediate,
                                     in_if.in_value));
      if (out_if.valid && out_if.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected (value %h)",
                   $time, out_if.out_value);
          nfail++;
        end else begin
          e = expected_q.pop_front();
          if (out_if.out_value !== e.out_value) begin
            $display("%0t: out_value expected %h actual %h", $time, e.out_value,
                     out_if.out_value);
            nfail++;
          end
          if (out_if.out_valid !== e.out_valid) begin
            $display("%0t: out_valid expected %b actual %b", $time, e.out_valid,
                     out_if.out_valid);
            nfail++;
          end
          if (out_if.halted !== e.halted) begin
            $display("%0t: halted expected %b actual %b", $time, e.halted,
                     out_if.halted);
            nfail++;
          end
          if (out_if.error_code !== e.error_code) begin
            $display("%0t: error_code expected %0d actual %0d", $time, e.error_code,
                     out_if.error_code);
            nfail++;
          end
        end
      end
      fail_count <= nfail;
      outstanding <= expected_q.size();
    end
  end

endmodule

/* sim/stack_machine_executor_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_executor_tb
// Drives the stack machine executor with directed and random instruction
// streams under several divide thresholds and idle patterns, ending with one
// halting instruction and items that must be ignored; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module stack_machine_executor_tb;

  localparam sme_pkg::cmd_t CMD_HALT       = 4'd9;
  localparam logic [3:0]  ADDR_THRESHOLD = 4'd0;
  localparam logic [47:0] Q_ONE          = 48'h1_000000;
  localparam logic [46:0] THR_MAX        = {47{1'b1}};
  localparam int          WATCHDOG_LIMIT = 20000;
  localparam int          ITEMS_PER_PHASE = 255;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  int          fail_count;
  int          outstanding;
  int          idle_pct;
  int          stall_pct;
  int          sc;
  logic [46:0] cur_thr;
  int          quiet_cycles = 0;

  sme_in_if  in_ch ();
  sme_out_if out_ch ();

  stack_machine_executor dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_if   (in_ch.sink),
    .out_if  (out_ch.source)
  );

  sme_checker #(.DEPTH(64)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [47:0] rand_q();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(6))
      0: return sme_pkg::VMAX;
      1: return sme_pkg::VMIN;
      2: return 48'($signed(r[47:0]) >>> 22);
      3: return 48'($signed(r[47:0]) >>> 10);
      4: return 48'($signed(r[47:0]) >>> 40);
      default: return r[47:0];
    endcase
  endfunction

  // divisor whose magnitude is not below the current threshold
  function automatic logic [47:0] rand_divisor();
    logic [47:0] lo;
    logic [47:0] m;
    logic [63:0] r;
    r = {$urandom, $urandom};
    lo = (cur_thr == 0) ? 48'd1 : {1'b0, cur_thr};
    case ($urandom_range(3))
      0: m = lo;
      1: m = 48'h8000_0000_0000;
      2: m = lo + 48'(r[23:0]);
      default: m = lo + 48'(r % (64'h8000_0000_0000 - lo + 1));
    endcase
    if (m > 48'h8000_0000_0000) m = 48'h8000_0000_0000;
    if (m == 48'h8000_0000_0000 || $urandom_range(1)) return 48'(-m);
    return m;
  endfunction

  // ready is sampled ahead of the edge, where it cannot change any more
  task automatic send(sme_pkg::cmd_t c, logic [2:0] rs, logic [47:0] imm);
    bit taken;
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= c;
    in_ch.reg_sel   <= rs;
    in_ch.immediate <= (c == sme_pkg::CMD_IN) ? rand_q() : imm;
    in_ch.in_value  <= (c == sme_pkg::CMD_IN) ? imm : rand_q();
    do begin
      @(negedge clk_i);
      taken = in_ch.ready;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // wait for the machine to drain, then write the threshold over the port
  task automatic write_threshold(logic [46:0] value);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= ADDR_THRESHOLD;
    pwdata  <= {17'b0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_thr = value;
  endtask

  // one well-formed step that never halts the machine
  task automatic random_step();
    int k;
    k = $urandom_range(9);
    if (k == 6 && sc <= 62) begin
      send(sme_pkg::CMD_PUSH, 3'd4 + 3'($urandom_range(3)), rand_divisor());
      send(sme_pkg::CMD_IN, 3'($urandom_range(7)), rand_q());
      send(sme_pkg::CMD_DIV, 3'($urandom_range(7)), rand_q());
      sc++;
    end else if (k == 7 && sc <= 63) begin
      send(sme_pkg::CMD_PUSH, 3'd4, rand_q() & sme_pkg::VMAX);
      send(sme_pkg::CMD_SQRT, 3'($urandom_range(7)), rand_q());
      sc++;
    end else if (k == 5 && sc >= 2) begin
      case ($urandom_range(2))
        0: send(sme_pkg::CMD_MUL, 3'($urandom_range(7)), rand_q());
        1: send(sme_pkg::CMD_ADD, 3'($urandom_range(7)), rand_q());
        default: send(sme_pkg::CMD_SUB, 3'($urandom_range(7)), rand_q());
      endcase
      sc--;
    end else if (k == 3 && sc > 0) begin
      send(sme_pkg::CMD_POP, 3'($urandom_range(7)), rand_q());
      sc--;
    end else if (k == 2 && sc < 64) begin
      send(sme_pkg::CMD_IN, 3'($urandom_range(7)), rand_q());
      sc++;
    end else if (k <= 1 && sc < 64) begin
      send(sme_pkg::CMD_PUSH, 3'($urandom_range(7)), rand_q());
      sc++;
    end else if (sc > 0) begin
      send(sme_pkg::CMD_OUT, 3'($urandom_range(7)), rand_q());
      sc--;
    end else begin
      send(sme_pkg::CMD_PUSH, 3'($urandom_range(7)), rand_q());
      sc++;
    end
  endtask

  // a short sequence ending in one instruction that halts the machine, chosen by the seed
  task automatic halt_machine();
    case ($urandom_range(4))
      0: begin
        send(sme_pkg::CMD_PUSH, 3'd4,
             (cur_thr > 1) ? 48'($urandom_range(1) ? 0 : 1) : 48'd0);
        send(sme_pkg::CMD_IN, 3'd4, rand_q());
        send(sme_pkg::CMD_DIV, 3'd4, rand_q());
      end
      1: begin
        while (sc > 0) begin
          send(sme_pkg::CMD_OUT, 3'd4, rand_q());
          sc--;
        end
        send($urandom_range(1) ? sme_pkg::CMD_OUT : sme_pkg::CMD_SUB, 3'd4, rand_q());
      end
      2: begin
        while (sc < 64) begin
          send(sme_pkg::CMD_PUSH, 3'd4, rand_q());
          sc++;
        end
        send($urandom_range(1) ? sme_pkg::CMD_PUSH : sme_pkg::CMD_IN, 3'd4, rand_q());
      end
      3: begin
        send(sme_pkg::CMD_PUSH, 3'd4, rand_q() | sme_pkg::VMIN);
        send(sme_pkg::CMD_SQRT, 3'd4, rand_q());
      end
      default: send(sme_pkg::cmd_t'($urandom_range(15, CMD_HALT)), 3'($urandom_range(7)),
                    rand_q());
    endcase
  endtask

  initial begin
    rst_ni          <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.cmd       <= sme_pkg::CMD_PUSH;
    in_ch.reg_sel   <= '0;
    in_ch.immediate <= '0;
    in_ch.in_value  <= '0;
    idle_pct  = 0;
    stall_pct = 0;
    sc        = 0;
    cur_thr   = 47'd1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: saturation at both ends, registers, every operation
    send(sme_pkg::CMD_PUSH, 3'd4, sme_pkg::VMAX);
    send(sme_pkg::CMD_PUSH, 3'd4, sme_pkg::VMAX);
    send(sme_pkg::CMD_ADD,  3'd4, '0);
    send(sme_pkg::CMD_OUT,  3'd4, '0);
    send(sme_pkg::CMD_PUSH, 3'd4, sme_pkg::VMIN);
    send(sme_pkg::CMD_PUSH, 3'd5, sme_pkg::VMIN);
    send(sme_pkg::CMD_ADD,  3'd4, '0);
    send(sme_pkg::CMD_POP,  3'd0, '0);
    send(sme_pkg::CMD_PUSH, 3'd0, '0);
    send(sme_pkg::CMD_OUT,  3'd4, '0);
    send(sme_pkg::CMD_IN,   3'd4, sme_pkg::VMAX);
    send(sme_pkg::CMD_IN,   3'd4, sme_pkg::VMIN);
    send(sme_pkg::CMD_SUB,  3'd4, '0);
    send(sme_pkg::CMD_OUT,  3'd4, '0);
    send(sme_pkg::CMD_IN,   3'd4, 48'(Q_ONE << 1));
    send(sme_pkg::CMD_IN,   3'd4, sme_pkg::VMAX);
    send(sme_pkg::CMD_MUL,  3'd4, '0);
    send(sme_pkg::CMD_POP,  3'd7, '0);
    send(sme_pkg::CMD_PUSH, 3'd4, 48'd1);
    send(sme_pkg::CMD_PUSH, 3'd4, sme_pkg::VMAX);
    send(sme_pkg::CMD_DIV,  3'd4, '0);
    send(sme_pkg::CMD_OUT,  3'd4, '0);
    send(sme_pkg::CMD_PUSH, 3'd4, sme_pkg::VMAX);
    send(sme_pkg::CMD_SQRT, 3'd4, '0);
    send(sme_pkg::CMD_OUT,  3'd4, '0);
    send(sme_pkg::CMD_PUSH, 3'd6, '0);
    send(sme_pkg::CMD_SQRT, 3'd4, '0);
    send(sme_pkg::CMD_POP,  3'd6, '0);

    // random phases under several thresholds and idle patterns
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_threshold(47'd0);
        1: write_threshold(THR_MAX);
        2: write_threshold(47'($urandom_range(32'h00FF_FFFF)));
        3: write_threshold(47'({$urandom, $urandom}));
        4: write_threshold(47'd1);
        default: write_threshold(47'($urandom_range(32'h3FFF_FFFF)));
      endcase
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 88; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 88; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) random_step();
    end

    // halt once, then items that must be ignored
    idle_pct  = 19;
    stall_pct = 19;
    halt_machine();
    for (int i = 0; i < 6; i++)
      send(sme_pkg::cmd_t'($urandom_range(15)), 3'($urandom_range(7)), rand_q());
    in_ch.valid <= 1'b0;

    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
sv/sme_pkg.sv
sv/sme_if.sv
sv/sme_front.sv
sv/sme_divsqrt.sv
sv/sme_back.sv
sv/stack_machine_executor.sv
sim/sme_checker.sv
sim/stack_machine_executor_tb.sv
